FILE: hw/rtl/fmtk_pkg.sv
// ----------------------------------------------------------------------------
// fmtk_pkg
// Types and constants shared by the FM timer / key-on register block.
// ----------------------------------------------------------------------------
package fmtk_pkg;

   localparam int RF_DEPTH  = 512;
   localparam int RF_ADDR_W = 9;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [7:0] TA_HIGH_ADDR = 8'h24;
   localparam logic [7:0] TA_LOW_ADDR  = 8'h25;
   localparam logic [7:0] TB_ADDR      = 8'h26;
   localparam logic [7:0] CTRL_ADDR    = 8'h27;
   localparam logic [7:0] KEY_ADDR     = 8'h28;
   localparam logic [7:0] BANK_SPLIT   = 8'h30;

   localparam logic [7:0] CTRL_STORE_MASK = 8'hCF;
   localparam logic [1:0] CSM_MODE        = 2'd2;
   localparam logic [3:0] ALL_SLOTS       = 4'hF;
   localparam logic [2:0] CHAN_NONE       = 3'd7;
   localparam int         NUM_CHAN        = 6;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

   // control register bit positions
   localparam int CTRL_LOAD_A  = 0;
   localparam int CTRL_LOAD_B  = 1;
   localparam int CTRL_EN_A    = 2;
   localparam int CTRL_EN_B    = 3;
   localparam int CTRL_RST_A   = 4;
   localparam int CTRL_RST_B   = 5;

   typedef struct packed {
      logic [1:0] op;
      logic       bank;
      logic [7:0] reg_addr;
      logic [7:0] write_data;
   } fmtk_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       timer_a_flag;
      logic       timer_b_flag;
      logic       key_started;
      logic [2:0] started_channel;
   } fmtk_rsp_type;

   // key-on channel code to channel index
   function automatic logic [2:0] chan_map(input logic [2:0] code);
      logic [2:0] chan;
      case (code)
         3'd0:    chan = 3'd0;
         3'd1:    chan = 3'd1;
         3'd2:    chan = 3'd2;
         3'd4:    chan = 3'd3;
         3'd5:    chan = 3'd4;
         3'd6:    chan = 3'd5;
         default: chan = CHAN_NONE;
      endcase
      return chan;
   endfunction

endpackage

FILE: hw/rtl/fmtk_ram.sv
// ----------------------------------------------------------------------------
// fmtk_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fmtk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fmtk_core.sv
// ----------------------------------------------------------------------------
// fmtk_core
// Timer, flag, control and key-on state; processes one transaction per fire.
// ----------------------------------------------------------------------------
module fmtk_core
   import fmtk_pkg::*;
#(
   parameter int TIMER_A_SCALE = 1,
   parameter int TIMER_A_LIMIT = 1024,
   parameter int TIMER_B_SCALE = 16,
   parameter int TIMER_B_LIMIT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  fmtk_req_type item,
   input  logic [7:0]   mem_rdata,
   output fmtk_rsp_type result
);

   localparam int A_SCALE_W = $clog2(TIMER_A_SCALE + 1);
   localparam int B_SCALE_W = $clog2(TIMER_B_SCALE + 1);
   localparam int A_PROD_W  = (10 + A_SCALE_W > 17) ? 10 + A_SCALE_W : 17;
   localparam int B_PROD_W  = (8 + B_SCALE_W > 17) ? 8 + B_SCALE_W : 17;

   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  ta_high_ff, ta_high_in;
   logic [1:0]  ta_low_ff, ta_low_in;
   logic [7:0]  tb_ff, tb_in;
   logic [15:0] count_a_ff, count_a_in;
   logic [15:0] count_b_ff, count_b_in;
   logic        flag_a_ff, flag_a_in;
   logic        flag_b_ff, flag_b_in;
   logic [3:0]  mask_ff [NUM_CHAN];
   logic [3:0]  mask_in [NUM_CHAN];

   logic [A_PROD_W-1:0] preset_a_prod;
   logic [B_PROD_W-1:0] preset_b_prod;
   logic [15:0]         preset_a;
   logic [15:0]         preset_b;

   assign preset_a_prod = A_PROD_W'({ta_high_ff, ta_low_ff}) * A_PROD_W'(TIMER_A_SCALE);
   assign preset_b_prod = B_PROD_W'(tb_ff) * B_PROD_W'(TIMER_B_SCALE);
   assign preset_a = (preset_a_prod > A_PROD_W'(COUNT_MAX)) ? COUNT_MAX
                                                           : preset_a_prod[15:0];
   assign preset_b = (preset_b_prod > B_PROD_W'(COUNT_MAX)) ? COUNT_MAX
                                                           : preset_b_prod[15:0];

   always_comb begin
      logic [2:0] chan;
      logic [3:0] slots;
      logic [7:0] ctrl_t;

      ctrl_in    = ctrl_ff;
      ta_high_in = ta_high_ff;
      ta_low_in  = ta_low_ff;
      tb_in      = tb_ff;
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      flag_a_in  = flag_a_ff;
      flag_b_in  = flag_b_ff;
      mask_in    = mask_ff;
      chan       = chan_map(item.write_data[2:0]);
      slots      = item.write_data[7:4];
      ctrl_t     = ctrl_ff;

      result.read_data       = '0;
      result.key_started     = 1'b0;
      result.started_channel = '0;

      case (item.op)
         OP_WRITE: begin
            if (item.reg_addr == TA_HIGH_ADDR) begin
               ta_high_in = item.write_data;
            end
            if (item.reg_addr == TA_LOW_ADDR) begin
               ta_low_in = item.write_data[1:0];
            end
            if (item.reg_addr == TB_ADDR) begin
               tb_in = item.write_data;
            end
            if (item.reg_addr == CTRL_ADDR) begin
               ctrl_in = item.write_data & CTRL_STORE_MASK;
               if (!ctrl_ff[CTRL_LOAD_A] && item.write_data[CTRL_LOAD_A]) begin
                  count_a_in = preset_a;
               end
               if (!ctrl_ff[CTRL_LOAD_B] && item.write_data[CTRL_LOAD_B]) begin
                  count_b_in = preset_b;
               end
               if (item.write_data[CTRL_RST_A]) begin
                  flag_a_in = 1'b0;
               end
               if (item.write_data[CTRL_RST_B]) begin
                  flag_b_in = 1'b0;
               end
            end
            if (item.reg_addr == KEY_ADDR && chan != CHAN_NONE) begin
               if ((slots & ~mask_ff[chan]) != 4'h0) begin
                  result.key_started     = 1'b1;
                  result.started_channel = chan;
               end
               mask_in[chan] = slots;
            end
         end
         OP_READ: begin
            if (!item.bank && item.reg_addr == CTRL_ADDR) begin
               result.read_data = ctrl_ff;
            end else begin
               result.read_data = mem_rdata;
            end
         end
         OP_TICK: begin
            if (ctrl_t[CTRL_LOAD_A]) begin
               count_a_in = (count_a_ff == COUNT_MAX) ? COUNT_MAX : count_a_ff + 16'd1;
               if (count_a_in >= 16'(TIMER_A_LIMIT)) begin
                  ctrl_t[CTRL_LOAD_A] = 1'b0;
                  if (ctrl_t[CTRL_EN_A]) begin
                     flag_a_in = 1'b1;
                  end
                  if (ctrl_t[7:6] == CSM_MODE) begin
                     mask_in[2] = ALL_SLOTS;
                  end
               end
            end
            if (ctrl_t[CTRL_LOAD_B]) begin
               count_b_in = (count_b_ff == COUNT_MAX) ? COUNT_MAX : count_b_ff + 16'd1;
               if (count_b_in >= 16'(TIMER_B_LIMIT)) begin
                  ctrl_t[CTRL_LOAD_B] = 1'b0;
                  if (ctrl_t[CTRL_EN_B]) begin
                     flag_b_in = 1'b1;
                  end
               end
            end
            ctrl_in = ctrl_t;
         end
         default: begin
         end
      endcase

      result.timer_a_flag = flag_a_in;
      result.timer_b_flag = flag_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff    <= '0;
         ta_high_ff <= '0;
         ta_low_ff  <= '0;
         tb_ff      <= '0;
         count_a_ff <= '0;
         count_b_ff <= '0;
         flag_a_ff  <= 1'b0;
         flag_b_ff  <= 1'b0;
         for (int i = 0; i < NUM_CHAN; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (fire) begin
         ctrl_ff    <= ctrl_in;
         ta_high_ff <= ta_high_in;
         ta_low_ff  <= ta_low_in;
         tb_ff      <= tb_in;
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
         flag_a_ff  <= flag_a_in;
         flag_b_ff  <= flag_b_in;
         mask_ff    <= mask_in;
      end
   end

endmodule

FILE: hw/rtl/fm_timer_keyon_register_block.sv
// ----------------------------------------------------------------------------
// fm_timer_keyon_register_block
// Register banks, timers A/B, overflow flags and key-on masks of an FM synth.
//
//   channel  direction  payload         handshake
//   req_     in         fmtk_req_type   req_valid / req_stall
//   rsp_     out        fmtk_rsp_type   rsp_valid / rsp_stall
//
// One transaction per cycle sustained while rsp_stall is low; rsp_valid comes
// from the response register, which follows the input register (with RAM read).
// After reset a clearing pass writes zero to all 512 register-file bytes,
// one per cycle; req_stall stays high throughout the pass.
// A stalled response holds in its register while the input stage keeps
// accepting until it is full.
// ----------------------------------------------------------------------------
module fm_timer_keyon_register_block
   import fmtk_pkg::*;
#(
   parameter int TIMER_A_SCALE = 1,
   parameter int TIMER_A_LIMIT = 1024,
   parameter int TIMER_B_SCALE = 16,
   parameter int TIMER_B_LIMIT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  fmtk_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output fmtk_rsp_type rsp_data
);

   logic                 clearing_ff;
   logic [RF_ADDR_W-1:0] clr_addr_ff;
   logic                 s1_valid_ff;
   fmtk_req_type         s1_data_ff;
   logic                 rsp_valid_ff;
   fmtk_rsp_type         rsp_data_ff;
   logic                 fwd_hit_ff;
   logic [7:0]           fwd_data_ff;

   logic                 accept;
   logic                 advance;
   logic                 mem_we;
   logic [RF_ADDR_W-1:0] mem_waddr;
   logic [7:0]           mem_wdata;
   logic [RF_ADDR_W-1:0] mem_raddr;
   logic [RF_ADDR_W-1:0] item_waddr;
   logic                 item_we;
   logic [7:0]           ram_rdata;
   logic [7:0]           mem_rdata;
   fmtk_rsp_type         result;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clearing_ff || (s1_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   assign item_we    = advance && (s1_data_ff.op == OP_WRITE);
   assign item_waddr = {(s1_data_ff.reg_addr < BANK_SPLIT) ? 1'b0 : s1_data_ff.bank,
                        s1_data_ff.reg_addr};
   assign mem_raddr  = {req_data.bank, req_data.reg_addr};

   assign mem_we    = clearing_ff || item_we;
   assign mem_waddr = clearing_ff ? clr_addr_ff : item_waddr;
   assign mem_wdata = clearing_ff ? 8'h00 : s1_data_ff.write_data;

   assign mem_rdata = fwd_hit_ff ? fwd_data_ff : ram_rdata;

   fmtk_ram #(
      .WIDTH (8),
      .DEPTH (RF_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (accept),
      .rd_addr (mem_raddr),
      .rd_data (ram_rdata)
   );

   fmtk_core #(
      .TIMER_A_SCALE (TIMER_A_SCALE),
      .TIMER_A_LIMIT (TIMER_A_LIMIT),
      .TIMER_B_SCALE (TIMER_B_SCALE),
      .TIMER_B_LIMIT (TIMER_B_LIMIT)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (s1_data_ff),
      .mem_rdata (mem_rdata),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + RF_ADDR_W'(1);
            if (clr_addr_ff == RF_ADDR_W'(RF_DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_hit_ff  <= item_we && (item_waddr == mem_raddr);
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff  <= req_data;
         fwd_data_ff <= s1_data_ff.write_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/fmtk_checker.sv
// ----------------------------------------------------------------------------
// fmtk_checker
// Port-level checks for the FM timer / key-on register block.
// ----------------------------------------------------------------------------
module fmtk_checker
   import fmtk_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input fmtk_req_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input fmtk_rsp_type rsp_data
);

   // clearing pass holds off input right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("input open or response valid right after reset");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_chan_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.key_started |-> rsp_data.started_channel == 3'd0)
      else $error("started_channel set without key_started");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.started_channel != 3'd6 && rsp_data.started_channel != 3'd7)
      else $error("started_channel out of range");

endmodule

bind fm_timer_keyon_register_block fmtk_checker u_fmtk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: dv/fm_timer_keyon_register_block_checker.sv
// ----------------------------------------------------------------------------
// fm_timer_keyon_register_block_checker
// Watches both channels of the timer / key-on register block. Each accepted
// request transaction is run through a local model of the register banks,
// timers, overflow flags and slot masks. Each accepted response is compared
// field by field against the oldest predicted response.
// ----------------------------------------------------------------------------
module fm_timer_keyon_register_block_checker
   import fmtk_pkg::*;
#(
   parameter int TIMER_A_SCALE = 1,
   parameter int TIMER_A_LIMIT = 1024,
   parameter int TIMER_B_SCALE = 16,
   parameter int TIMER_B_LIMIT = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  fmtk_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  fmtk_rsp_type rsp_data,
   output int           mismatch_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]   regs [2][256];
   logic [15:0]  count_a;
   logic [15:0]  count_b;
   logic         flag_a;
   logic         flag_b;
   logic [3:0]   slot_mask [NUM_CHAN];
   fmtk_rsp_type rsp_queue [$];
   fmtk_rsp_type want_rsp;
   fmtk_rsp_type next_rsp;

   function automatic logic [15:0] clamp16(input longint v);
      return (v > longint'(COUNT_MAX)) ? COUNT_MAX : 16'(v);
   endfunction

   // codes 3 and 7 select no channel; upper half maps onto channels 3..5
   function automatic logic [2:0] key_channel(input logic [2:0] code);
      if (code[1:0] == 2'b11)
         return CHAN_NONE;
      return code[2] ? 3'(code[1:0]) + 3'd3 : {1'b0, code[1:0]};
   endfunction

   function automatic string rsp_text(input fmtk_rsp_type r);
      return $sformatf("rd=%02h fa=%0d fb=%0d ks=%0d ch=%0d", r.read_data,
                       r.timer_a_flag, r.timer_b_flag, r.key_started, r.started_channel);
   endfunction

   function automatic fmtk_rsp_type predict_access(input fmtk_req_type acc);
      fmtk_rsp_type res;
      logic         b;
      logic [7:0]   prev;
      logic [2:0]   ch;
      logic [3:0]   new_slots;
      res = '0;
      case (acc.op)
         OP_WRITE: begin
            b = (acc.reg_addr < BANK_SPLIT) ? 1'b0 : acc.bank;
            prev = regs[b][acc.reg_addr];
            regs[b][acc.reg_addr] = acc.write_data;
            if (acc.reg_addr == CTRL_ADDR) begin
               regs[0][CTRL_ADDR] = acc.write_data & CTRL_STORE_MASK;
               if (!prev[CTRL_LOAD_A] && acc.write_data[CTRL_LOAD_A])
                  count_a = clamp16(longint'({regs[0][TA_HIGH_ADDR],
                                              regs[0][TA_LOW_ADDR][1:0]}) * TIMER_A_SCALE);
               if (!prev[CTRL_LOAD_B] && acc.write_data[CTRL_LOAD_B])
                  count_b = clamp16(longint'(regs[0][TB_ADDR]) * TIMER_B_SCALE);
               if (acc.write_data[CTRL_RST_A])
                  flag_a = 1'b0;
               if (acc.write_data[CTRL_RST_B])
                  flag_b = 1'b0;
            end else if (acc.reg_addr == KEY_ADDR) begin
               ch = key_channel(acc.write_data[2:0]);
               if (ch != CHAN_NONE) begin
                  new_slots = acc.write_data[7:4] & ~slot_mask[ch];
                  if (new_slots != 4'd0) begin
                     res.key_started     = 1'b1;
                     res.started_channel = ch;
                  end
                  slot_mask[ch] = acc.write_data[7:4];
               end
            end
         end
         OP_READ: begin
            res.read_data = regs[acc.bank][acc.reg_addr];
         end
         OP_TICK: begin
            if (regs[0][CTRL_ADDR][CTRL_LOAD_A]) begin
               count_a = clamp16(longint'(count_a) + 1);
               if (count_a >= TIMER_A_LIMIT) begin
                  regs[0][CTRL_ADDR][CTRL_LOAD_A] = 1'b0;
                  if (regs[0][CTRL_ADDR][CTRL_EN_A])
                     flag_a = 1'b1;
                  if (regs[0][CTRL_ADDR][7:6] == CSM_MODE)
                     slot_mask[2] = ALL_SLOTS;
               end
            end
            if (regs[0][CTRL_ADDR][CTRL_LOAD_B]) begin
               count_b = clamp16(longint'(count_b) + 1);
               if (count_b >= TIMER_B_LIMIT) begin
                  regs[0][CTRL_ADDR][CTRL_LOAD_B] = 1'b0;
                  if (regs[0][CTRL_ADDR][CTRL_EN_B])
                     flag_b = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      res.timer_a_flag = flag_a;
      res.timer_b_flag = flag_b;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input fmtk_rsp_type want,
                                  input fmtk_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected %s, got %s", $realtime, what,
                  rsp_text(want), rsp_text(got));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 256; i++) begin
            regs[0][i] = 8'd0;
            regs[1][i] = 8'd0;
         end
         for (int i = 0; i < NUM_CHAN; i++)
            slot_mask[i] = 4'd0;
         count_a = 16'd0;
         count_b = 16'd0;
         flag_a  = 1'b0;
         flag_b  = 1'b0;
         mismatch_count = 0;
         rsp_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_queue.size() == 0) begin
               report_mismatch("response with no transaction outstanding", '0, rsp_data);
            end else begin
               want_rsp = rsp_queue.pop_front();
               if (rsp_data.read_data       !== want_rsp.read_data       ||
                   rsp_data.timer_a_flag    !== want_rsp.timer_a_flag    ||
                   rsp_data.timer_b_flag    !== want_rsp.timer_b_flag    ||
                   rsp_data.key_started     !== want_rsp.key_started     ||
                   rsp_data.started_channel !== want_rsp.started_channel)
                  report_mismatch("response mismatch", want_rsp, rsp_data);
            end
         end
         if (req_valid && !req_stall) begin
            next_rsp  = predict_access(req_data);
            rsp_queue = {rsp_queue, next_rsp};
         end
      end
      pending_count = rsp_queue.size();
   end

endmodule

FILE: dv/fm_timer_keyon_register_block_tb.sv
// ----------------------------------------------------------------------------
// fm_timer_keyon_register_block_tb
// Drives register writes, reads and timer ticks into the block with random
// burst gaps and random response stalls. A short directed sequence covers the
// bank split, unused ops, timer overflow in CSM mode and key-on corner codes;
// random timer, key-on and register sequences follow. Checking is done by
// the checker module instantiated beside the block.
// ----------------------------------------------------------------------------
module fm_timer_keyon_register_block_tb
   import fmtk_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TA_SCALE = 1;
   localparam int TA_LIMIT = 1024;
   localparam int TB_SCALE = 16;
   localparam int TB_LIMIT = 4096;
   localparam int NUM_ITEMS = 800;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         rsp_stall = 1'b0;
   fmtk_req_type req_data  = '0;
   logic         req_stall;
   logic         rsp_valid;
   fmtk_rsp_type rsp_data;
   int           mismatch_count;
   int           pending_count;

   int sent        = 0;
   int burst_left  = 0;
   int stall_mode  = 0;
   int stall_left  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   fm_timer_keyon_register_block #(
      .TIMER_A_SCALE(TA_SCALE),
      .TIMER_A_LIMIT(TA_LIMIT),
      .TIMER_B_SCALE(TB_SCALE),
      .TIMER_B_LIMIT(TB_LIMIT)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   fm_timer_keyon_register_block_checker #(
      .TIMER_A_SCALE(TA_SCALE),
      .TIMER_A_LIMIT(TA_LIMIT),
      .TIMER_B_SCALE(TB_SCALE),
      .TIMER_B_LIMIT(TB_LIMIT)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   // response stall pattern: free, light, heavy, periodic
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ((stall_left % 11) < 7);
      endcase
   end

   function automatic fmtk_req_type access(input logic [1:0] op, input logic bank,
                                           input logic [7:0] addr, input logic [7:0] data);
      fmtk_req_type acc;
      acc.op         = op;
      acc.bank       = bank;
      acc.reg_addr   = addr;
      acc.write_data = data;
      return acc;
   endfunction

   task automatic issue(input fmtk_req_type acc);
      req_valid <= 1'b1;
      req_data  <= acc;
      do @(posedge clock); while (req_stall);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic write_reg(input logic bank, input logic [7:0] addr, input logic [7:0] data);
      issue(access(OP_WRITE, bank, addr, data));
   endtask

   task automatic read_reg(input logic bank, input logic [7:0] addr);
      issue(access(OP_READ, bank, addr, 8'd0));
   endtask

   task automatic tick();
      issue(access(OP_TICK, 1'($urandom), 8'($urandom), 8'($urandom)));
   endtask

   task automatic timer_sequence();
      logic [7:0] ctrl;
      int         n;
      write_reg(1'($urandom), TA_HIGH_ADDR,
                ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hF8, 8'hFF)) : 8'($urandom));
      write_reg(1'($urandom), TA_LOW_ADDR, 8'($urandom));
      write_reg(1'($urandom), TB_ADDR,
                ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hFE, 8'hFF)) : 8'($urandom));
      if ($urandom_range(0, 1) == 0)
         write_reg(1'($urandom), CTRL_ADDR, 8'($urandom) & 8'hFC);
      ctrl = 8'($urandom);
      ctrl[CTRL_LOAD_A] = ($urandom_range(0, 3) != 0);
      ctrl[CTRL_LOAD_B] = ($urandom_range(0, 3) != 0);
      write_reg(1'($urandom), CTRL_ADDR, ctrl);
      n = $urandom_range(1, 36);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0)
            read_reg(1'b0, CTRL_ADDR);
         else
            tick();
      end
   endtask

   task automatic key_sequence();
      int n;
      n = $urandom_range(1, 6);
      repeat (n) begin
         write_reg(1'($urandom), KEY_ADDR, 8'($urandom));
         if ($urandom_range(0, 4) == 0)
            read_reg(1'b0, KEY_ADDR);
      end
   endtask

   task automatic register_sequence();
      logic       bank;
      logic [7:0] addr;
      bank = 1'($urandom);
      addr = 8'($urandom);
      write_reg(bank, addr, 8'($urandom));
      read_reg(bank, addr);
      read_reg(1'($urandom), 8'($urandom));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // bank split and unused op
      read_reg(1'b0, 8'h00);
      read_reg(1'b1, 8'hFF);
      write_reg(1'b1, 8'hFF, 8'hFF);
      read_reg(1'b1, 8'hFF);
      write_reg(1'b0, 8'h00, 8'h00);
      write_reg(1'b1, 8'h10, 8'hA5);
      read_reg(1'b1, 8'h10);
      read_reg(1'b0, 8'h10);
      issue(access(OP_UNUSED, 1'b1, 8'hFF, 8'hFF));

      // timer A overflow on the first tick, CSM keys channel 2
      write_reg(1'b0, TA_HIGH_ADDR, 8'hFF);
      write_reg(1'b0, TA_LOW_ADDR, 8'hFF);
      write_reg(1'b0, TB_ADDR, 8'hFF);
      write_reg(1'b0, CTRL_ADDR, 8'hBF);
      tick();
      write_reg(1'b0, KEY_ADDR, 8'hF2);
      write_reg(1'b0, KEY_ADDR, 8'hF0);
      write_reg(1'b1, KEY_ADDR, 8'h16);
      write_reg(1'b0, KEY_ADDR, 8'hF3);
      write_reg(1'b0, KEY_ADDR, 8'hF7);
      write_reg(1'b0, KEY_ADDR, 8'h06);
      read_reg(1'b0, CTRL_ADDR);

      // flag reset, then reload A with its flag disabled
      write_reg(1'b0, CTRL_ADDR, 8'h30);
      write_reg(1'b0, CTRL_ADDR, 8'h01);
      tick();
      read_reg(1'b0, KEY_ADDR);

      while (sent < NUM_ITEMS) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: timer_sequence();
            9, 10, 11, 12, 13:         key_sequence();
            14, 15, 16, 17:            register_sequence();
            default: issue(access(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom)));
         endcase
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("fm_timer_keyon_register_block test passed");
      else
         $display("fm_timer_keyon_register_block test failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("fm_timer_keyon_register_block test failed");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/fmtk_pkg.sv
hw/rtl/fmtk_ram.sv
hw/rtl/fmtk_core.sv
hw/rtl/fm_timer_keyon_register_block.sv
hw/rtl/fmtk_checker.sv
dv/fm_timer_keyon_register_block_checker.sv
dv/fm_timer_keyon_register_block_tb.sv
